@@ design/bcre_pkg.sv @@
// Package for the boot request retry engine: item, state and register types,
// field codes and reset values. No dependencies.
package bcre_pkg;

  localparam int unsigned BACKOFF_CAP_DEF = 60;
  localparam int unsigned CFG_ADDR_W      = 5;
  localparam int unsigned CFG_DATA_W      = 64;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_REPLY = 2'd2;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_SENT    = 2'd1;
  localparam logic [1:0] EV_ADDR    = 2'd2;
  localparam logic [1:0] EV_GAVE_UP = 2'd3;

  localparam logic [1:0] REG_RETRY_LIMIT = 2'd0;
  localparam logic [1:0] REG_NO_BACKOFF  = 2'd1;
  localparam logic [1:0] REG_CLIENT_HW   = 2'd2;
  localparam logic [1:0] REG_XID         = 2'd3;

  localparam logic [3:0] RETRY_LIMIT_RST = 4'd6;
  localparam logic [3:0] DEFAULT_RETRIES = 4'd6;
  localparam logic [7:0] BOOT_REPLY      = 8'd2;
  localparam logic [4:0] REQ_SAT         = 5'd31;
  localparam logic [15:0] SECS_SAT       = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  reply_opcode;
    logic        reply_full_length;
    logic [47:0] reply_hw_addr;
    logic [31:0] reply_xid;
    logic [31:0] reply_your_addr;
    logic [1:0]  random_draw;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [15:0] elapsed_secs;
    logic [31:0] offered_addr;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  retry_limit;
    logic        no_backoff;
    logic [47:0] client_hw_addr;
    logic [31:0] transaction_id;
  } cfg_t;

  typedef struct packed {
    logic        session_active;
    logic [5:0]  backoff_secs;
    logic [5:0]  timer_left;
    logic [4:0]  requests_sent;
    logic [15:0] seconds_elapsed;
  } sess_t;

endpackage

@@ design/bootp_client_retry_engine_unit.sv @@
// Top level of the boot request retry engine: input register, step logic,
// result register and config port. Depends on bcre_pkg, bcre_regs, bcre_step.
//
//   channel  ports                               direction
//   input    in_valid / in_ready / in_data       item in (in_item_t)
//   result   out_valid / out_ready / out_data    one result per item
//   config   cfg_psel .. cfg_pready, 64-bit      registers at 8*index
//
// One transaction per cycle sustained while results are taken. Path: input
// register, then step logic into the result register, which also holds state.
// Synchronous active-low reset clears valids and session state (backoff to 1) and resets the config registers.
// A stalled result holds the result register; the input register then fills
// and in_ready drops until the result is taken.
module bootp_client_retry_engine_unit import bcre_pkg::*; #(
  parameter int unsigned BACKOFF_CAP = BACKOFF_CAP_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t      cfg;
  sess_t     sess_r, sess_nxt;
  in_item_t  in_data_r;
  logic      in_valid_r;
  out_item_t out_data_r, res;
  logic      out_valid_r;
  logic      adv;

  assign cfg_pready = 1'b1;

  bcre_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  bcre_step #(.BACKOFF_CAP(BACKOFF_CAP)) u_step (
    .item     (in_data_r),
    .sess     (sess_r),
    .cfg      (cfg),
    .sess_nxt (sess_nxt),
    .res      (res)
  );

  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sess_r.session_active  <= 1'b0;
      sess_r.backoff_secs    <= 6'd1;
      sess_r.timer_left      <= '0;
      sess_r.requests_sent   <= '0;
      sess_r.seconds_elapsed <= '0;
    end else begin
      if (in_ready)
        in_valid_r <= in_valid;
      if (adv) begin
        out_valid_r <= 1'b1;
        sess_r      <= sess_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid)
      in_data_r <= in_data;
    if (adv)
      out_data_r <= res;
  end

  a_timer_in_backoff: assert property (@(posedge clk) disable iff (!rst_n)
    sess_r.timer_left <= sess_r.backoff_secs)
    else $error("retransmit timer above backoff");

  a_backoff_range: assert property (@(posedge clk) disable iff (!rst_n)
    sess_r.backoff_secs != 6'd0 && sess_r.backoff_secs <= 6'(BACKOFF_CAP))
    else $error("backoff out of range");

  a_idle_timer: assert property (@(posedge clk) disable iff (!rst_n)
    !sess_r.session_active |-> sess_r.timer_left == 6'd0)
    else $error("timer running without session");

  a_quiet_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.event_res == EV_NONE |->
      out_data_r.elapsed_secs == 16'd0 && out_data_r.offered_addr == 32'd0)
    else $error("payload on empty result");

endmodule

@@ design/bcre_regs.sv @@
// Configuration register file behind the APB-style port.
// Depends on bcre_pkg.
module bcre_regs import bcre_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output cfg_t                  cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[CFG_ADDR_W-1:CFG_ADDR_W-2];
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_limit    <= RETRY_LIMIT_RST;
      cfg_r.no_backoff     <= 1'b0;
      cfg_r.client_hw_addr <= '0;
      cfg_r.transaction_id <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_RETRY_LIMIT: cfg_r.retry_limit    <= pwdata[3:0];
        REG_NO_BACKOFF:  cfg_r.no_backoff     <= pwdata[0];
        REG_CLIENT_HW:   cfg_r.client_hw_addr <= pwdata[47:0];
        REG_XID:         cfg_r.transaction_id <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RETRY_LIMIT: prdata = {60'd0, cfg_r.retry_limit};
      REG_NO_BACKOFF:  prdata = {63'd0, cfg_r.no_backoff};
      REG_CLIENT_HW:   prdata = {16'd0, cfg_r.client_hw_addr};
      REG_XID:         prdata = {32'd0, cfg_r.transaction_id};
      default:         prdata = '0;
    endcase
  end

endmodule

@@ design/bcre_step.sv @@
// Next-state and result logic for one transaction: session start, tick,
// retransmit with backoff, reply match. Depends on bcre_pkg.
module bcre_step import bcre_pkg::*; #(
  parameter int unsigned BACKOFF_CAP = BACKOFF_CAP_DEF
) (
  input  in_item_t  item,
  input  sess_t     sess,
  input  cfg_t      cfg,
  output sess_t     sess_nxt,
  output out_item_t res
);

  localparam logic [5:0] CAP6 = 6'(BACKOFF_CAP);
  localparam logic [6:0] CAP7 = 7'(BACKOFF_CAP);

  logic [3:0]  limit;
  logic        do_send;
  logic [5:0]  bo_base;
  logic [4:0]  req_base;
  logic [4:0]  req_n;
  logic [1:0]  jit;
  logic [6:0]  bo_sum;
  logic [5:0]  bo_n;
  logic [15:0] secs_n;
  logic        reply_ok;

  always_comb begin
    limit = (cfg.retry_limit == 4'd0) ? DEFAULT_RETRIES : cfg.retry_limit;
    jit   = (item.random_draw == 2'd3) ? 2'd0 : item.random_draw;

    secs_n   = (sess.seconds_elapsed != SECS_SAT) ? sess.seconds_elapsed + 16'd1
                                                  : sess.seconds_elapsed;
    reply_ok = sess.session_active && item.reply_full_length &&
               (item.reply_opcode == BOOT_REPLY) &&
               (item.reply_hw_addr == cfg.client_hw_addr) &&
               (item.reply_xid == cfg.transaction_id);

    sess_nxt = sess;
    res      = '0;
    do_send  = 1'b0;

    case (item.kind)
      KIND_START: begin
        sess_nxt.session_active  = 1'b1;
        sess_nxt.seconds_elapsed = '0;
        do_send = 1'b1;
      end
      KIND_TICK: begin
        if (sess.session_active) begin
          sess_nxt.seconds_elapsed = secs_n;
          if (sess.timer_left <= 6'd1) begin
            do_send = 1'b1;
            res.elapsed_secs = secs_n;
          end else begin
            sess_nxt.timer_left = sess.timer_left - 6'd1;
          end
        end
      end
      KIND_REPLY: begin
        if (reply_ok) begin
          sess_nxt.session_active = 1'b0;
          sess_nxt.timer_left     = '0;
          res.event_res           = EV_ADDR;
          res.offered_addr        = item.reply_your_addr;
        end
      end
      default: ;
    endcase

    // shared send unit; a start begins from a fresh count and backoff
    bo_base  = (item.kind == KIND_START) ? 6'd1 : sess.backoff_secs;
    req_base = (item.kind == KIND_START) ? 5'd0 : sess.requests_sent;
    req_n    = (req_base != REQ_SAT) ? req_base + 5'd1 : req_base;
    bo_sum   = {bo_base, 1'b0} + {5'd0, jit};
    if (cfg.no_backoff)
      bo_n = 6'd1;
    else if (bo_base >= CAP6)
      bo_n = bo_base;
    else if (bo_sum > CAP7)
      bo_n = CAP6;
    else
      bo_n = bo_sum[5:0];

    if (do_send) begin
      sess_nxt.requests_sent = req_n;
      sess_nxt.backoff_secs  = bo_n;
      if (req_n > {1'b0, limit}) begin
        sess_nxt.session_active = 1'b0;
        sess_nxt.timer_left     = '0;
        res.event_res           = EV_GAVE_UP;
      end else begin
        sess_nxt.timer_left = bo_n;
        res.event_res       = EV_SENT;
      end
    end
  end

endmodule

@@ bench/tb_bootp_client_retry_engine_unit.sv @@
// Testbench for bootp_client_retry_engine_unit: a directed table, then random sessions, all
// checked by the session predictor or a typed row's want. Depends on bcre_pkg and the RTL.
module tb_bootp_client_retry_engine_unit;
  import bcre_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned PHASE_ITEMS = 300;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  bootp_client_retry_engine_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_sel;
    logic [63:0] wval;
    in_item_t    item;
    bit          typed;
    out_item_t   want;
  } dir_row_t;

  // client session shadow and register shadow
  logic        sess_live;
  logic [5:0]  backoff_s;
  logic [5:0]  timer_s;
  logic [4:0]  reqs_sent;
  logic [15:0] secs_count;
  logic [3:0]  lim_reg;
  logic        nobo_reg;
  logic [47:0] hw_reg;
  logic [31:0] xid_reg;

  out_item_t   due_events[$];
  out_item_t   head_event;
  dir_row_t    rows[$];
  int unsigned fails = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned live_count;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bootp_client_retry_engine_unit test failed");
      $finish;
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_events.size() == 0) begin
        $error("result with no expectation waiting: %h", out_data);
        fails++;
      end else begin
        head_event = due_events.pop_front();
        if (out_data.event_res !== head_event.event_res) begin
          $error("event_res expected %0d actual %0d", head_event.event_res, out_data.event_res);
          fails++;
        end
        if (out_data.elapsed_secs !== head_event.elapsed_secs) begin
          $error("elapsed_secs expected %0d actual %0d",
                 head_event.elapsed_secs, out_data.elapsed_secs);
          fails++;
        end
        if (out_data.offered_addr !== head_event.offered_addr) begin
          $error("offered_addr expected %h actual %h",
                 head_event.offered_addr, out_data.offered_addr);
          fails++;
        end
      end
    end
  end

  function automatic logic [1:0] issue_request(input logic [1:0] draw);
    logic [3:0] lim;
    logic [6:0] nb;
    lim = (lim_reg == 4'd0) ? DEFAULT_RETRIES : lim_reg;
    if (reqs_sent != REQ_SAT) reqs_sent++;
    if (!nobo_reg) begin
      if (backoff_s < BACKOFF_CAP_DEF) begin
        nb = {backoff_s, 1'b0} + ((draw == 2'd3) ? 2'd0 : draw);
        if (nb > BACKOFF_CAP_DEF) nb = 7'(BACKOFF_CAP_DEF);
        backoff_s = nb[5:0];
      end
    end else begin
      backoff_s = 6'd1;
    end
    if (reqs_sent > lim) begin
      sess_live = 1'b0;
      timer_s = 6'd0;
      return EV_GAVE_UP;
    end
    timer_s = backoff_s;
    return EV_SENT;
  endfunction

  function automatic out_item_t advance_client(input in_item_t it);
    out_item_t r;
    r = '0;
    case (it.kind)
      KIND_START: begin
        sess_live = 1'b1;
        secs_count = 16'd0;
        backoff_s = 6'd1;
        reqs_sent = 5'd0;
        r.event_res = issue_request(it.random_draw);
      end
      KIND_TICK: begin
        if (sess_live) begin
          if (secs_count != SECS_SAT) secs_count++;
          if (timer_s <= 6'd1) begin
            timer_s = 6'd0;
            r.elapsed_secs = secs_count;
            r.event_res = issue_request(it.random_draw);
          end else begin
            timer_s--;
          end
        end
      end
      KIND_REPLY: begin
        if (sess_live && it.reply_full_length && it.reply_opcode == BOOT_REPLY &&
            it.reply_hw_addr == hw_reg && it.reply_xid == xid_reg) begin
          sess_live = 1'b0;
          timer_s = 6'd0;
          r.event_res = EV_ADDR;
          r.offered_addr = it.reply_your_addr;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic out_item_t result_of(input logic [1:0] e, input logic [15:0] s,
                                          input logic [31:0] a);
    out_item_t r;
    r.event_res = e;
    r.elapsed_secs = s;
    r.offered_addr = a;
    return r;
  endfunction

  function automatic dir_row_t item_row(input logic [1:0] kind, input logic [7:0] op,
                                        input logic full, input logic [47:0] hw,
                                        input logic [31:0] xid, input logic [31:0] yaddr,
                                        input logic [1:0] draw, input bit typed = 1'b0,
                                        input out_item_t want = '0);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.reg_sel = REG_RETRY_LIMIT;
    r.wval = '0;
    r.item = '{kind: kind, reply_opcode: op, reply_full_length: full, reply_hw_addr: hw,
               reply_xid: xid, reply_your_addr: yaddr, random_draw: draw};
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [1:0] sel, input logic [63:0] val);
    dir_row_t r;
    r.is_cfg = 1'b1;
    r.reg_sel = sel;
    r.wval = val;
    r.item = '0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] sel, input logic [63:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {sel, 3'b000};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (sel)
      REG_RETRY_LIMIT: lim_reg = val[3:0];
      REG_NO_BACKOFF:  nobo_reg = val[0];
      REG_CLIENT_HW:   hw_reg = val[47:0];
      REG_XID:         xid_reg = val[31:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want,
                           output bit live);
    out_item_t pred;
    int unsigned gap;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    live = sess_live || it.kind == KIND_START;
    pred = advance_client(it);
    due_events.push_back(typed ? want : pred);
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_episode();
    int unsigned len;
    int unsigned n;
    int unsigned pick;
    bit long_haul;
    bit live;
    in_item_t it;
    settle_pipeline();
    pick = $urandom_range(3);
    write_reg(REG_RETRY_LIMIT, (pick == 0) ? 64'd0 : (pick == 1) ? 64'd1 :
                               (pick == 2) ? 64'd15 : 64'($urandom_range(15)));
    write_reg(REG_NO_BACKOFF, 64'($urandom_range(1)));
    if ($urandom_range(2) == 0) begin
      pick = $urandom_range(3);
      write_reg(REG_CLIENT_HW, (pick == 0) ? 64'd0 : (pick == 1) ? 64'hFFFF_FFFF_FFFF :
                               {16'd0, 16'($urandom), 32'($urandom)});
    end
    if ($urandom_range(2) == 0) write_reg(REG_XID, 64'($urandom));
    long_haul = $urandom_range(1);
    len = $urandom_range(250, 20);
    if (len > PHASE_ITEMS - live_count) len = PHASE_ITEMS - live_count;
    n = 0;
    while (n < len) begin
      it.kind = 2'($urandom_range(3));
      it.reply_opcode = 8'($urandom);
      it.reply_full_length = 1'($urandom);
      it.reply_hw_addr = {16'($urandom), 32'($urandom)};
      it.reply_xid = 32'($urandom);
      it.reply_your_addr = 32'($urandom);
      it.random_draw = 2'($urandom_range(3));
      pick = $urandom_range(99);
      if (!sess_live && $urandom_range(3) == 0) begin
        it.kind = KIND_START;
      end else if (pick < (long_haul ? 94 : 75)) begin
        it.kind = KIND_TICK;
      end else if (pick < (long_haul ? 97 : 91)) begin
        it.kind = KIND_REPLY;
        it.reply_opcode = BOOT_REPLY;
        it.reply_full_length = 1'b1;
        it.reply_hw_addr = hw_reg;
        it.reply_xid = xid_reg;
        if (long_haul || pick >= 83) begin
          case ($urandom_range(3))
            0: if (it.reply_opcode == BOOT_REPLY) it.reply_opcode = 8'($urandom_range(255, 3));
            1: it.reply_full_length = 1'b0;
            2: it.reply_hw_addr ^= 48'd1 << $urandom_range(47);
            default: it.reply_xid ^= 32'd1 << $urandom_range(31);
          endcase
        end
      end else if (!long_haul && pick < 95) begin
        it.kind = KIND_START;
      end else if (pick < 98) begin
        it.kind = KIND_UNUSED;
      end
      send_item(it, 1'b0, '0, live);
      if (live) begin
        n++;
        live_count++;
      end
    end
  endtask

  initial begin
    bit live;
    int unsigned idle_set[4];
    int unsigned stall_set[4];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    idle_pct = 0;
    stall_pct = 0;
    sess_live = 1'b0;
    backoff_s = 6'd1;
    timer_s = 6'd0;
    reqs_sent = 5'd0;
    secs_count = 16'd0;
    lim_reg = RETRY_LIMIT_RST;
    nobo_reg = 1'b0;
    hw_reg = '0;
    xid_reg = '0;
    idle_set = '{0, 80, 0, 10};
    stall_set = '{0, 0, 80, 10};

    rows.push_back(item_row(KIND_TICK, 8'h00, 1'b0, '0, '0, '0, 2'd0,
                            1'b1, result_of(EV_NONE, 16'd0, 32'd0)));
    rows.push_back(item_row(KIND_REPLY, BOOT_REPLY, 1'b1, '0, '0, 32'h0A00_0001, 2'd0,
                            1'b1, result_of(EV_NONE, 16'd0, 32'd0)));
    rows.push_back(item_row(KIND_UNUSED, 8'hFF, 1'b1, '1, '1, '1, 2'd3,
                            1'b1, result_of(EV_NONE, 16'd0, 32'd0)));
    rows.push_back(item_row(KIND_START, 8'h00, 1'b0, '0, '0, '0, 2'd3,
                            1'b1, result_of(EV_SENT, 16'd0, 32'd0)));
    rows.push_back(item_row(KIND_TICK, 8'h00, 1'b0, '0, '0, '0, 2'd1));
    rows.push_back(item_row(KIND_TICK, 8'h00, 1'b0, '0, '0, '0, 2'd2));
    rows.push_back(item_row(KIND_REPLY, 8'h01, 1'b1, '0, '0, 32'h1, 2'd0));
    rows.push_back(item_row(KIND_REPLY, BOOT_REPLY, 1'b0, '0, '0, 32'h2, 2'd0));
    rows.push_back(item_row(KIND_REPLY, BOOT_REPLY, 1'b1, '1, '0, 32'h3, 2'd0));
    rows.push_back(item_row(KIND_REPLY, BOOT_REPLY, 1'b1, '0, '1, 32'h4, 2'd0));
    rows.push_back(item_row(KIND_REPLY, BOOT_REPLY, 1'b1, '0, '0, 32'hFFFF_FFFF, 2'd0,
                            1'b1, result_of(EV_ADDR, 16'd0, 32'hFFFF_FFFF)));
    rows.push_back(item_row(KIND_TICK, 8'h00, 1'b0, '0, '0, '0, 2'd0,
                            1'b1, result_of(EV_NONE, 16'd0, 32'd0)));
    rows.push_back(item_row(KIND_START, 8'h00, 1'b0, '0, '0, '0, 2'd0));
    rows.push_back(item_row(KIND_START, 8'h00, 1'b0, '0, '0, '0, 2'd1));
    rows.push_back(item_row(KIND_REPLY, BOOT_REPLY, 1'b1, '0, '0, 32'h1234_5678, 2'd0));
    rows.push_back(cfg_row(REG_RETRY_LIMIT, 64'd1));
    rows.push_back(cfg_row(REG_NO_BACKOFF, 64'd1));
    rows.push_back(cfg_row(REG_CLIENT_HW, 64'hFFFF_FFFF_FFFF));
    rows.push_back(cfg_row(REG_XID, 64'hFFFF_FFFF));
    rows.push_back(item_row(KIND_START, 8'h00, 1'b0, '0, '0, '0, 2'd2));
    rows.push_back(item_row(KIND_TICK, 8'h00, 1'b0, '0, '0, '0, 2'd0,
                            1'b1, result_of(EV_GAVE_UP, 16'd1, 32'd0)));
    rows.push_back(item_row(KIND_START, 8'h00, 1'b0, '0, '0, '0, 2'd0));
    rows.push_back(item_row(KIND_REPLY, BOOT_REPLY, 1'b1, '1, '1, 32'h0, 2'd0,
                            1'b1, result_of(EV_ADDR, 16'd0, 32'd0)));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        settle_pipeline();
        write_reg(rows[i].reg_sel, rows[i].wval);
      end else begin
        send_item(rows[i].item, rows[i].typed, rows[i].want, live);
      end
    end

    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      live_count = 0;
      while (live_count < PHASE_ITEMS) run_episode();
    end

    settle_pipeline();
    if (fails == 0) begin
      $display("bootp_client_retry_engine_unit test passed");
    end else begin
      $display("bootp_client_retry_engine_unit test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/bcre_pkg.sv
design/bcre_regs.sv
design/bcre_step.sv
design/bootp_client_retry_engine_unit.sv
bench/tb_bootp_client_retry_engine_unit.sv
